### rtl/scmc_pkg.sv
package scmc_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] MODE_DISC  = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_DASH  = 2'd2;
  localparam logic [1:0] MODE_SWEEP = 2'd3;

  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_ACK   = 2'd1;
  localparam logic [1:0] REPLY_PONG  = 2'd2;

  localparam logic [2:0] LED_OFF   = 3'd0;
  localparam logic [2:0] LED_RED   = 3'd1;
  localparam logic [2:0] LED_GREEN = 3'd2;
  localparam logic [2:0] LED_BLUE  = 3'd4;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // longest command text, in bytes
  localparam int CMD_BYTES = 14;
  localparam int CMD_W     = CMD_BYTES * 8;

  // command texts, first character in the top byte, right-justified
  localparam logic [CMD_W-1:0] PROBE_TXT = 112'h50726F6265206473504943205246;
  localparam int               PROBE_LEN = 14;
  localparam logic [31:0]      PING_TXT  = "Ping";
  localparam int               PING_LEN  = 4;
  localparam logic [79:0]      DASH_TXT  = "SetStaDash";
  localparam int               DASH_LEN  = 10;
  localparam logic [79:0]      IDLE_TXT  = "SetStaIdle";
  localparam int               IDLE_LEN  = 10;
  localparam logic [71:0]      SWEEP_TXT = "SetStaFre";
  localparam int               SWEEP_LEN = 9;

endpackage

### rtl/scmc_if.sv
interface scmc_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [7:0]             rx_byte;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output rx_byte, output sample, input ready);
  modport sink   (input valid, input opcode, input rx_byte, input sample, output ready);
endinterface

interface scmc_out_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [2:0]             led_color;
  logic                   link_up;
  logic [1:0]             reply;
  logic                   restart_timeout;
  logic                   report_valid;
  logic [SAMPLE_BITS-1:0] report_value;

  modport source (
    output valid, output mode, output led_color, output link_up, output reply,
    output restart_timeout, output report_valid, output report_value, input ready
  );
  modport sink (
    input valid, input mode, input led_color, input link_up, input reply,
    input restart_timeout, input report_valid, input report_value, output ready
  );
endinterface

### rtl/serial_command_mode_controller.sv
// Serial command and mode controller. Every beat on in_ch yields exactly one beat on out_ch,
// and one beat is taken per clock while in_ch.ready is high: a byte, tick or timeout updates
// the line buffer, command flags, link, mode and moving-average window in the cycle it is
// accepted, and its result lands in the output register the next cycle. in_ch.ready stays
// high while the output register is empty or being drained. A newline checks the buffered
// line against the five commands in parallel; the average is the running window sum times a
// fixed reciprocal, one multiplier in the tick path.
module serial_command_mode_controller
  import scmc_pkg::*;
#(
  parameter int LINE_BYTES  = 16,
  parameter int WINDOW_SIZE = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  scmc_in_if.sink  in_ch,
  scmc_out_if.source out_ch
);

  localparam int POS_W        = $clog2(LINE_BYTES);
  localparam int SLOT_W       = $clog2(WINDOW_SIZE);
  localparam int SUM_W        = SAMPLE_BITS + SLOT_W;
  localparam int RECIP_SHIFT  = SUM_W + SLOT_W;
  localparam longint RECIP_INT =
    ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE);
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_INT);
  localparam int PROD_W       = 2 * SUM_W + 1;
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(LINE_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);

  typedef logic [7:0] line_t [LINE_BYTES];
  typedef logic [SAMPLE_BITS-1:0] window_t [WINDOW_SIZE];

  function automatic logic line_match(input line_t ln, input logic [CMD_W-1:0] txt,
                                      input int len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i <= CMD_BYTES; i++) begin
      if (i < len) begin
        if (ln[i] != txt[(len-1-i)*8 +: 8]) ok = 1'b0;
      end else if (i == len) begin
        if (ln[i] != 8'd0) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  line_t                  line_r, line_nxt, line_eff;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   link_r, link_nxt;
  logic                   dash_req_r, dash_req_nxt;
  logic                   idle_req_r, idle_req_nxt;
  logic                   sweep_req_r, sweep_req_nxt;
  logic [1:0]             mode_r, mode_nxt;
  window_t                win_r, win_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt, sum_upd;
  logic [SAMPLE_BITS-1:0] last_r, last_nxt;

  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic [7:0]             wr_byte;
  logic                   is_nl;

  logic                   accept;
  logic                   out_valid_r;
  logic [1:0]             out_mode_r;
  logic [2:0]             out_led_r, led;
  logic                   out_link_r;
  logic [1:0]             out_reply_r, reply;
  logic                   out_restart_r, restart;
  logic                   out_rep_valid_r, rep_valid;
  logic [SAMPLE_BITS-1:0] out_rep_value_r, rep_value;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_nl   = (in_ch.rx_byte == NEWLINE_CODE);
  assign wr_byte = is_nl ? 8'd0 : in_ch.rx_byte;

  always_comb begin
    for (int i = 0; i < LINE_BYTES; i++) begin
      line_eff[i] = (POS_W'(i) == pos_r) ? wr_byte : line_r[i];
    end
  end

  assign sum_upd = sum_r - SUM_W'(win_r[slot_r]) + SUM_W'(in_ch.sample);
  assign prod    = PROD_W'(sum_upd) * PROD_W'(RECIP);
  assign avg     = prod[RECIP_SHIFT +: SAMPLE_BITS];

  always_comb begin
    case (mode_r)
      MODE_DISC:  led = LED_RED;
      MODE_IDLE:  led = LED_OFF;
      MODE_DASH:  led = LED_GREEN;
      default:    led = LED_BLUE;
    endcase
  end

  always_comb begin
    line_nxt      = line_r;
    pos_nxt       = pos_r;
    link_nxt      = link_r;
    dash_req_nxt  = dash_req_r;
    idle_req_nxt  = idle_req_r;
    sweep_req_nxt = sweep_req_r;
    mode_nxt      = mode_r;
    win_nxt       = win_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    reply         = REPLY_NONE;
    restart       = 1'b0;
    rep_valid     = 1'b0;
    rep_value     = '0;

    if (accept) begin
      case (in_ch.opcode)
        OP_BYTE: begin
          if (is_nl) begin
            restart = 1'b1;
            if (line_match(line_eff, PROBE_TXT, PROBE_LEN)) begin
              reply    = REPLY_ACK;
              link_nxt = 1'b1;
            end else if (line_match(line_eff, CMD_W'(PING_TXT), PING_LEN)) begin
              reply = REPLY_PONG;
            end else if (line_match(line_eff, CMD_W'(DASH_TXT), DASH_LEN)) begin
              dash_req_nxt = 1'b1;
            end else if (line_match(line_eff, CMD_W'(IDLE_TXT), IDLE_LEN)) begin
              idle_req_nxt = 1'b1;
            end else if (line_match(line_eff, CMD_W'(SWEEP_TXT), SWEEP_LEN)) begin
              sweep_req_nxt = 1'b1;
            end
            for (int i = 0; i < LINE_BYTES; i++) line_nxt[i] = 8'd0;
            pos_nxt = '0;
          end else begin
            line_nxt = line_eff;
            pos_nxt  = (pos_r == POS_LAST) ? pos_r : pos_r + POS_W'(1);
          end
        end
        OP_TICK: begin
          case (mode_r)
            MODE_DISC: begin
              if (link_r) mode_nxt = MODE_IDLE;
            end
            MODE_IDLE: begin
              if (!link_r) begin
                mode_nxt = MODE_DISC;
              end else if (idle_req_r) begin
                idle_req_nxt = 1'b0;
              end else if (dash_req_r) begin
                dash_req_nxt = 1'b0;
                mode_nxt     = MODE_DASH;
              end else if (sweep_req_r) begin
                sweep_req_nxt = 1'b0;
                mode_nxt      = MODE_SWEEP;
              end
            end
            MODE_DASH: begin
              if (!link_r) begin
                mode_nxt = MODE_DISC;
              end else if (dash_req_r) begin
                dash_req_nxt = 1'b0;
              end else if (idle_req_r) begin
                idle_req_nxt = 1'b0;
                mode_nxt     = MODE_IDLE;
              end else begin
                win_nxt[slot_r] = in_ch.sample;
                sum_nxt         = sum_upd;
                slot_nxt        = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
                if (avg != last_r) begin
                  rep_valid = 1'b1;
                  rep_value = avg;
                  last_nxt  = avg;
                end
              end
            end
            default: begin
              if (!link_r) begin
                mode_nxt = MODE_DISC;
              end else if (sweep_req_r) begin
                sweep_req_nxt = 1'b0;
              end else if (idle_req_r) begin
                idle_req_nxt = 1'b0;
                mode_nxt     = MODE_IDLE;
              end
            end
          endcase
        end
        OP_TIMEOUT: begin
          link_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_BYTES; i++) line_r[i] <= 8'd0;
      for (int i = 0; i < WINDOW_SIZE; i++) win_r[i] <= '0;
      pos_r       <= '0;
      link_r      <= 1'b0;
      dash_req_r  <= 1'b0;
      idle_req_r  <= 1'b0;
      sweep_req_r <= 1'b0;
      mode_r      <= MODE_DISC;
      slot_r      <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      line_r      <= line_nxt;
      win_r       <= win_nxt;
      pos_r       <= pos_nxt;
      link_r      <= link_nxt;
      dash_req_r  <= dash_req_nxt;
      idle_req_r  <= idle_req_nxt;
      sweep_req_r <= sweep_req_nxt;
      mode_r      <= mode_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode_r      <= mode_nxt;
      out_led_r       <= led;
      out_link_r      <= link_nxt;
      out_reply_r     <= reply;
      out_restart_r   <= restart;
      out_rep_valid_r <= rep_valid;
      out_rep_value_r <= rep_value;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mode            = out_mode_r;
  assign out_ch.led_color       = out_led_r;
  assign out_ch.link_up         = out_link_r;
  assign out_ch.reply           = out_reply_r;
  assign out_ch.restart_timeout = out_restart_r;
  assign out_ch.report_valid    = out_rep_valid_r;
  assign out_ch.report_value    = out_rep_value_r;

endmodule
